### rtl/inpp_pkg.sv
// shared types, codes and constants for the nibble program packer
package inpp_pkg;

   localparam int INST_DEPTH = 4096;
   localparam int SLOT_W     = 12;
   localparam int READ_W     = 16;
   localparam int MAX_CODES  = 10;
   localparam int MAX_BYTES  = 5;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      MODE_START = 3'd0,
      MODE_STOP  = 3'd1,
      MODE_WRITE = 3'd2,
      MODE_READ  = 3'd3,
      MODE_SLEEP = 3'd4,
      MODE_END   = 3'd5,
      MODE_RESET = 3'd6
   } mode_type;

   localparam logic [3:0] CODE_END     = 4'h0;
   localparam logic [3:0] CODE_CLOCK_L = 4'h2;
   localparam logic [3:0] CODE_CLOCK_H = 4'h3;
   localparam logic [3:0] CODE_DATA_L  = 4'h4;
   localparam logic [3:0] CODE_DATA_H  = 4'h5;
   localparam logic [3:0] CODE_RESET   = 4'h6;
   localparam logic [3:0] CODE_SLEEP   = 4'h7;
   localparam logic [3:0] CODE_BIT0    = 4'h8;
   localparam logic [3:0] CODE_BIT1    = 4'hc;
   localparam logic [3:0] CODE_READ    = 4'hd;
   localparam logic [3:0] CODE_ACK0    = 4'he;

   typedef struct packed {
      logic [8*MAX_BYTES-1:0] bytes;
      logic [2:0]             nbytes;
      logic [READ_W-1:0]      read_index;
   } entry_type;

endpackage

### rtl/inpp_front.sv
// front end: expands one operation into codes and packs them into bytes
module inpp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept_i,
   input  logic [2:0]           mode_i,
   input  logic [7:0]           data_byte_i,
   input  logic                 last_byte_i,
   output logic                 push_o,
   output inpp_pkg::entry_type  entry_o
);
   import inpp_pkg::*;

   logic [3:0]              pending_ff, pending_in;
   logic                    odd_ff, odd_in;
   logic [READ_W-1:0]       read_counter_ff, read_counter_in;
   logic [4*(MAX_CODES-1)-1:0] codes;
   logic [3:0]              ncodes;
   logic [3:0]              ntotal;
   logic [3:0]              last_idx;
   logic [5:0]              last_pos;
   logic [4*MAX_CODES-1:0]  vec;
   logic                    is_read;

   always_comb begin
      codes  = '0;
      ncodes = 4'd0;
      unique case (mode_i)
         MODE_START: begin
            codes[15:0] = {CODE_CLOCK_L, CODE_DATA_L, CODE_CLOCK_H, CODE_DATA_H};
            ncodes      = 4'd4;
         end
         MODE_STOP: begin
            codes[11:0] = {CODE_DATA_H, CODE_CLOCK_H, CODE_DATA_L};
            ncodes      = 4'd3;
         end
         MODE_WRITE: begin
            for (int j = 0; j < 8; j++) begin
               codes[4*j +: 4] = data_byte_i[7-j] ? CODE_BIT1 : CODE_BIT0;
            end
            codes[32 +: 4] = CODE_ACK0;
            ncodes         = 4'd9;
         end
         MODE_READ: begin
            for (int j = 0; j < 8; j++) begin
               codes[4*j +: 4] = CODE_READ;
            end
            codes[32 +: 4] = last_byte_i ? CODE_BIT1 : CODE_BIT0;
            ncodes         = 4'd9;
         end
         MODE_SLEEP: begin
            codes[3:0] = CODE_SLEEP;
            ncodes     = 4'd1;
         end
         MODE_END: begin
            codes[7:0] = {CODE_END, CODE_END};
            ncodes     = odd_ff ? 4'd1 : 4'd2;
         end
         MODE_RESET: begin
            codes[3:0] = CODE_RESET;
            ncodes     = 4'd1;
         end
         default: begin
            ncodes = 4'd0;
         end
      endcase
   end

   assign is_read  = (mode_i == MODE_READ);
   assign vec      = odd_ff ? {codes, pending_ff} : {4'h0, codes};
   assign ntotal   = ncodes + {3'd0, odd_ff};
   assign last_idx = ntotal - 4'd1;
   assign last_pos = {last_idx, 2'b00};

   assign entry_o.bytes      = vec;
   assign entry_o.nbytes     = ntotal[3:1];
   assign entry_o.read_index = is_read ? read_counter_ff : '0;
   assign push_o             = accept_i && (ntotal[3:1] != 3'd0);

   always_comb begin
      pending_in      = pending_ff;
      odd_in          = odd_ff;
      read_counter_in = read_counter_ff;
      if (accept_i) begin
         odd_in = ntotal[0];
         if (ntotal[0]) begin
            pending_in = vec[last_pos +: 4];
         end
         if (is_read) begin
            read_counter_in = read_counter_ff + READ_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff      <= '0;
         odd_ff          <= 1'b0;
         read_counter_ff <= '0;
      end else begin
         pending_ff      <= pending_in;
         odd_ff          <= odd_in;
         read_counter_ff <= read_counter_in;
      end
   end

   a_read_counter_holds: assert property (@(posedge clock) disable iff (reset)
      (accept_i && !is_read) |=> $stable(read_counter_ff))
      else $error("read counter moved on a non-read transaction");

   a_end_flushes: assert property (@(posedge clock) disable iff (reset)
      (accept_i && mode_i == MODE_END) |=> !odd_ff)
      else $error("end left a code pending");

endmodule

### rtl/inpp_queue.sv
// short queue of packed byte groups between front and back
module inpp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_i,
   input  inpp_pkg::entry_type  entry_i,
   input  logic                 pop_i,
   output logic                 full_o,
   output logic                 empty_o,
   output inpp_pkg::entry_type  head_o
);
   import inpp_pkg::*;

   entry_type  mem_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full_o  = (count_ff == 2'(QUEUE_DEPTH));
   assign empty_o = (count_ff == 2'd0);
   assign head_o  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_i ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_i  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push_i) - 2'(pop_i);
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         mem_ff[wr_ptr_ff] <= entry_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_i |-> !full_o)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop_i |-> !empty_o)
      else $error("pop from empty queue");

endmodule

### rtl/inpp_back.sv
// back end: emits queued bytes one per cycle unless rsp_stall holds the output, with slot numbering
module inpp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          empty_i,
   input  inpp_pkg::entry_type           head_i,
   output logic                          pop_o,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_instr_byte,
   output logic [inpp_pkg::SLOT_W-1:0]   rsp_slot_index,
   output logic                          rsp_wrapped,
   output logic [inpp_pkg::READ_W-1:0]   rsp_read_index,
   output logic                          rsp_last
);
   import inpp_pkg::*;

   localparam logic [SLOT_W:0] DEPTH_C = (SLOT_W + 1)'(INST_DEPTH);

   logic [2:0]        bidx_ff, bidx_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              valid_ff, valid_in;
   logic [7:0]        byte_ff;
   logic [SLOT_W-1:0] slot_out_ff;
   logic              wrapped_ff;
   logic [READ_W-1:0] read_index_ff;
   logic              last_ff;
   logic              out_free;
   logic              fire;
   logic              is_last;
   logic [5:0]        byte_pos;
   logic [SLOT_W:0]   slot_next;
   logic              wrap;

   assign out_free  = !valid_ff || !rsp_stall;
   assign fire      = !empty_i && out_free;
   assign is_last   = (bidx_ff == head_i.nbytes - 3'd1);
   assign byte_pos  = {bidx_ff, 3'b000};
   assign slot_next = {1'b0, slot_ff} + (SLOT_W + 1)'(1);
   assign wrap      = (slot_next >= DEPTH_C);
   assign pop_o     = fire && is_last;

   always_comb begin
      bidx_in  = bidx_ff;
      slot_in  = slot_ff;
      valid_in = out_free ? fire : valid_ff;
      if (fire) begin
         bidx_in = is_last ? 3'd0 : bidx_ff + 3'd1;
         slot_in = wrap ? '0 : slot_next[SLOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bidx_ff  <= '0;
         slot_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         bidx_ff  <= bidx_in;
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         byte_ff       <= head_i.bytes[byte_pos +: 8];
         slot_out_ff   <= slot_ff;
         wrapped_ff    <= wrap;
         read_index_ff <= head_i.read_index;
         last_ff       <= is_last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_instr_byte = byte_ff;
   assign rsp_slot_index = slot_out_ff;
   assign rsp_wrapped    = wrapped_ff;
   assign rsp_read_index = read_index_ff;
   assign rsp_last       = last_ff;

   a_head_not_empty: assert property (@(posedge clock) disable iff (reset)
      !empty_i |-> (head_i.nbytes != 3'd0))
      else $error("queued entry holds no bytes");

   a_slot_advance: assert property (@(posedge clock) disable iff (reset)
      (fire && !wrap) |=> (slot_ff == $past(slot_ff) + SLOT_W'(1)))
      else $error("slot position did not advance");

endmodule

### rtl/i2c_nibble_program_packer.sv
// top level of the nibble program packer: front, queue and back
//
//   channel | ports                                        | direction
//   req     | req_valid req_stall req_mode req_data_byte   | in
//           | req_last_byte                                |
//   rsp     | rsp_valid rsp_stall rsp_instr_byte           | out
//           | rsp_slot_index rsp_wrapped rsp_read_index    |
//           | rsp_last                                     |
//
// an operation yields 0 to 5 bytes; the back end emits one byte per cycle unless
// rsp_stall holds the output
// a two-entry queue lets new transactions enter while earlier bytes still drain
// req_stall is high only while the queue is full
// synchronous reset clears packing state, slot position, read index and queue
module i2c_nibble_program_packer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_mode,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_last_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_instr_byte,
   output logic [inpp_pkg::SLOT_W-1:0]   rsp_slot_index,
   output logic                          rsp_wrapped,
   output logic [inpp_pkg::READ_W-1:0]   rsp_read_index,
   output logic                          rsp_last
);
   import inpp_pkg::*;

   logic      accept;
   logic      push;
   logic      pop;
   logic      full;
   logic      empty;
   entry_type entry;
   entry_type head;

   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   inpp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept_i    (accept),
      .mode_i      (req_mode),
      .data_byte_i (req_data_byte),
      .last_byte_i (req_last_byte),
      .push_o      (push),
      .entry_o     (entry)
   );

   inpp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .entry_i (entry),
      .pop_i   (pop),
      .full_o  (full),
      .empty_o (empty),
      .head_o  (head)
   );

   inpp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .empty_i        (empty),
      .head_i         (head),
      .pop_o          (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_instr_byte (rsp_instr_byte),
      .rsp_slot_index (rsp_slot_index),
      .rsp_wrapped    (rsp_wrapped),
      .rsp_read_index (rsp_read_index),
      .rsp_last       (rsp_last)
   );

endmodule
